// ===== hdl/ortp_pkg.sv =====
// Shared types and constants for the oriented rectangle overlap test.
// No dependencies; imported by every module of the block.
`default_nettype none
package ortp_pkg;

    localparam int SIN_W = 16;               // signed Q14 sine/cosine, range +-16384
    localparam int T_W   = 17;               // Q16 quadrant fraction, 0..65536
    localparam int MAG_W = 15;               // unsigned quarter-sine magnitude

    localparam logic [16:0] POLY_A  = 17'd102918;
    localparam logic [15:0] POLY_B  = 16'd42120;
    localparam logic [12:0] POLY_C  = 13'd4738;
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [16:0] T_ONE   = 17'd65536;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int NUM_LANES = 4;

    typedef struct packed {
        logic x2_en;
        logic inner_en;
        logic poly_en;
        logic out_en;
    } ortp_sine_ctl_t;

    typedef struct packed {
        logic prod_en;
        logic sum_en;
        logic mul_en;
        logic ok_en;
    } ortp_lane_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/oriented_rect_overlap_test_unit.sv =====
// Oriented rectangle overlap test top level: input register, sine pipelines,
// four axis lanes and the merging output stage. Depends on ortp_pkg,
// ortp_sine and ortp_lane.
//
// Takes one rectangle pair per clock when the result side does not stall and
// returns one colliding bit per pair. Pairs pass through the eleven-register
// pipeline: input register, four stages of the sine polynomial, a quadrant
// stage, four stages in each axis lane and the output register. Every stage
// holds a valid bit and moves on when the next stage is free, so bubbles
// close up and new pairs are taken while a result waits.
// Touching rectangles count as colliding; a pair with no nonzero extent
// reports not colliding.
`default_nettype none
module oriented_rect_overlap_test_unit #(
    parameter int ANGLE_BITS = 12,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_a_center_x,
    input  wire logic signed [COORD_BITS-1:0] s_a_center_y,
    input  wire logic        [COORD_BITS-2:0] s_a_width,
    input  wire logic        [COORD_BITS-2:0] s_a_height,
    input  wire logic        [ANGLE_BITS-1:0] s_a_angle,
    input  wire logic signed [COORD_BITS-1:0] s_b_center_x,
    input  wire logic signed [COORD_BITS-1:0] s_b_center_y,
    input  wire logic        [COORD_BITS-2:0] s_b_width,
    input  wire logic        [COORD_BITS-2:0] s_b_height,
    input  wire logic        [ANGLE_BITS-1:0] s_b_angle,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_colliding
);
    import ortp_pkg::*;

    localparam int NS = 11;
    localparam int FB = ANGLE_BITS - 2;
    localparam int ST_QUAD = 5;
    localparam int ST_LANE = 6;
    localparam int ST_OK   = 9;
    localparam int ST_OUT  = 10;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    // payload carried down the pipe, one entry per stage
    logic [1:0]              qa_reg [0:ST_QUAD-1];
    logic [1:0]              qb_reg [0:ST_QUAD-1];
    logic signed [COORD_BITS:0] dx_reg [0:ST_QUAD];
    logic signed [COORD_BITS:0] dy_reg [0:ST_QUAD];
    logic [COORD_BITS-2:0]   wa_reg [0:ST_LANE+1];
    logic [COORD_BITS-2:0]   ha_reg [0:ST_LANE+1];
    logic [COORD_BITS-2:0]   wb_reg [0:ST_LANE+1];
    logic [COORD_BITS-2:0]   hb_reg [0:ST_LANE+1];
    logic [NUM_LANES-1:0]    pres_reg [0:ST_OK];

    logic [T_W-1:0] ta_reg, tca_reg, tb_reg, tcb_reg;
    logic [T_W-1:0] ta_next, tb_next;

    logic [MAG_W-1:0] sa_mag, ca_mag, sb_mag, cb_mag;
    logic signed [SIN_W-1:0] sna_reg, csa_reg, snb_reg, csb_reg;
    logic signed [SIN_W-1:0] sna_next, csa_next, snb_next, csb_next;

    logic signed [SIN_W-1:0] ax [NUM_LANES];
    logic signed [SIN_W-1:0] ay [NUM_LANES];
    logic [NUM_LANES-1:0]    ok;

    logic colliding_reg, colliding_next;

    ortp_sine_ctl_t sine_ctl;
    ortp_lane_ctl_t lane_ctl;

    // ready ripples back from the output register
    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= s_valid;
            for (int i = 1; i < NS; i++) begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_comb begin
        ta_next = T_W'(s_a_angle[FB-1:0]) << (16 - FB);
        tb_next = T_W'(s_b_angle[FB-1:0]) << (16 - FB);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ta_reg    <= ta_next;
            tca_reg   <= T_ONE - ta_next;
            tb_reg    <= tb_next;
            tcb_reg   <= T_ONE - tb_next;
            qa_reg[0] <= s_a_angle[ANGLE_BITS-1 -: 2];
            qb_reg[0] <= s_b_angle[ANGLE_BITS-1 -: 2];
            dx_reg[0] <= {s_a_center_x[COORD_BITS-1], s_a_center_x}
                       - {s_b_center_x[COORD_BITS-1], s_b_center_x};
            dy_reg[0] <= {s_a_center_y[COORD_BITS-1], s_a_center_y}
                       - {s_b_center_y[COORD_BITS-1], s_b_center_y};
            wa_reg[0] <= s_a_width;
            ha_reg[0] <= s_a_height;
            wb_reg[0] <= s_b_width;
            hb_reg[0] <= s_b_height;
            pres_reg[0] <= {s_b_height != '0, s_b_width != '0,
                            s_a_height != '0, s_a_width != '0};
        end
        for (int i = 1; i < ST_QUAD; i++) begin
            if (en[i]) begin
                qa_reg[i] <= qa_reg[i-1];
                qb_reg[i] <= qb_reg[i-1];
            end
        end
        for (int i = 1; i <= ST_QUAD; i++) begin
            if (en[i]) begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
            end
        end
        for (int i = 1; i <= ST_LANE + 1; i++) begin
            if (en[i]) begin
                wa_reg[i] <= wa_reg[i-1];
                ha_reg[i] <= ha_reg[i-1];
                wb_reg[i] <= wb_reg[i-1];
                hb_reg[i] <= hb_reg[i-1];
            end
        end
        for (int i = 1; i <= ST_OK; i++) begin
            if (en[i]) pres_reg[i] <= pres_reg[i-1];
        end
    end

    assign sine_ctl = '{x2_en: en[1], inner_en: en[2], poly_en: en[3], out_en: en[4]};

    ortp_sine u_sine_sa (.aclk(aclk), .ctl(sine_ctl), .t(ta_reg),  .mag(sa_mag));
    ortp_sine u_sine_ca (.aclk(aclk), .ctl(sine_ctl), .t(tca_reg), .mag(ca_mag));
    ortp_sine u_sine_sb (.aclk(aclk), .ctl(sine_ctl), .t(tb_reg),  .mag(sb_mag));
    ortp_sine u_sine_cb (.aclk(aclk), .ctl(sine_ctl), .t(tcb_reg), .mag(cb_mag));

    function automatic logic signed [SIN_W-1:0] pos(input logic [MAG_W-1:0] m);
        return $signed({1'b0, m});
    endfunction

    // quadrant symmetry
    always_comb begin
        unique case (qa_reg[ST_QUAD-1])
            QUAD_0: begin sna_next =  pos(sa_mag); csa_next =  pos(ca_mag); end
            QUAD_1: begin sna_next =  pos(ca_mag); csa_next = -pos(sa_mag); end
            QUAD_2: begin sna_next = -pos(sa_mag); csa_next = -pos(ca_mag); end
            QUAD_3: begin sna_next = -pos(ca_mag); csa_next =  pos(sa_mag); end
            default: begin sna_next = '0; csa_next = '0; end
        endcase
        unique case (qb_reg[ST_QUAD-1])
            QUAD_0: begin snb_next =  pos(sb_mag); csb_next =  pos(cb_mag); end
            QUAD_1: begin snb_next =  pos(cb_mag); csb_next = -pos(sb_mag); end
            QUAD_2: begin snb_next = -pos(sb_mag); csb_next = -pos(cb_mag); end
            QUAD_3: begin snb_next = -pos(cb_mag); csb_next =  pos(sb_mag); end
            default: begin snb_next = '0; csb_next = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[ST_QUAD]) begin
            sna_reg <= sna_next;
            csa_reg <= csa_next;
            snb_reg <= snb_next;
            csb_reg <= csb_next;
        end
    end

    // edge normals 0-1 and 1-2 of each rectangle
    always_comb begin
        ax[0] =  sna_reg; ay[0] = -csa_reg;
        ax[1] = -csa_reg; ay[1] = -sna_reg;
        ax[2] =  snb_reg; ay[2] = -csb_reg;
        ax[3] = -csb_reg; ay[3] = -snb_reg;
    end

    assign lane_ctl = '{prod_en: en[ST_LANE], sum_en: en[ST_LANE+1],
                        mul_en: en[ST_LANE+2], ok_en: en[ST_OK]};

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        ortp_lane #(.COORD_BITS(COORD_BITS)) u_lane (
            .aclk (aclk),
            .ctl  (lane_ctl),
            .ax   (ax[g]),
            .ay   (ay[g]),
            .sn_a (sna_reg),
            .cs_a (csa_reg),
            .sn_b (snb_reg),
            .cs_b (csb_reg),
            .dx   (dx_reg[ST_QUAD]),
            .dy   (dy_reg[ST_QUAD]),
            .w_a  (wa_reg[ST_LANE+1]),
            .h_a  (ha_reg[ST_LANE+1]),
            .w_b  (wb_reg[ST_LANE+1]),
            .h_b  (hb_reg[ST_LANE+1]),
            .ok   (ok[g])
        );
    end

    // a dropped axis cannot separate; no axis at all means no collision
    assign colliding_next = (|pres_reg[ST_OK]) && (&(ok | ~pres_reg[ST_OK]));

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) colliding_reg <= colliding_next;
    end

    assign m_valid     = valid_reg[ST_OUT];
    assign m_colliding = colliding_reg;

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_no_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_OK] && en[ST_OUT] && pres_reg[ST_OK] == '0) |=> !m_colliding)
        else $error("collision reported with no axis");

    a_sine_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_QUAD-1] |-> (sa_mag <= ONE_Q14 && ca_mag <= ONE_Q14
                                  && sb_mag <= ONE_Q14 && cb_mag <= ONE_Q14))
        else $error("sine magnitude above one");

    a_accept_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> s_ready)
        else $error("input refused with empty input stage");
`endif

endmodule
`default_nettype wire

// ===== hdl/ortp_sine.sv =====
// Four-stage pipelined first-quadrant sine polynomial, Q16 in, Q14 out.
// Depends on ortp_pkg.
`default_nettype none
module ortp_sine (
    input  wire logic                          aclk,
    input  wire ortp_pkg::ortp_sine_ctl_t      ctl,
    input  wire logic [ortp_pkg::T_W-1:0]      t,
    output logic      [ortp_pkg::MAG_W-1:0]    mag
);
    import ortp_pkg::*;

    logic [16:0]  x2_reg, x2_2_reg;
    logic [16:0]  t1_reg, t2_reg, t3_reg;
    logic [15:0]  inner_reg;
    logic [16:0]  poly_reg;
    logic [MAG_W-1:0] mag_reg;

    logic [33:0] tt;
    logic [29:0] xc;
    logic [32:0] xi;
    logic [33:0] tp;
    logic [18:0] rnd;

    always_comb begin
        tt  = 34'(t) * 34'(t);
        xc  = 30'(x2_reg) * 30'(POLY_C);
        xi  = 33'(x2_2_reg) * 33'(inner_reg);
        tp  = 34'(t3_reg) * 34'(poly_reg);
        rnd = (19'(tp[33:16]) + 19'd2) >> 2;
    end

    always_ff @(posedge aclk) begin
        if (ctl.x2_en) begin
            x2_reg <= tt[32:16];
            t1_reg <= t;
        end
        if (ctl.inner_en) begin
            inner_reg <= POLY_B - 16'(xc[29:16]);
            x2_2_reg  <= x2_reg;
            t2_reg    <= t1_reg;
        end
        if (ctl.poly_en) begin
            poly_reg <= POLY_A - xi[32:16];
            t3_reg   <= t2_reg;
        end
        if (ctl.out_en) begin
            mag_reg <= (rnd > 19'(ONE_Q14)) ? ONE_Q14 : rnd[MAG_W-1:0];
        end
    end

    assign mag = mag_reg;

endmodule
`default_nettype wire

// ===== hdl/ortp_lane.sv =====
// One separating-axis lane: projects both rectangles on one axis, four stages.
// Depends on ortp_pkg.
`default_nettype none
module ortp_lane #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire ortp_pkg::ortp_lane_ctl_t          ctl,
    input  wire logic signed [ortp_pkg::SIN_W-1:0] ax,
    input  wire logic signed [ortp_pkg::SIN_W-1:0] ay,
    input  wire logic signed [ortp_pkg::SIN_W-1:0] sn_a,
    input  wire logic signed [ortp_pkg::SIN_W-1:0] cs_a,
    input  wire logic signed [ortp_pkg::SIN_W-1:0] sn_b,
    input  wire logic signed [ortp_pkg::SIN_W-1:0] cs_b,
    input  wire logic signed [COORD_BITS:0]        dx,
    input  wire logic signed [COORD_BITS:0]        dy,
    input  wire logic        [COORD_BITS-2:0]      w_a,
    input  wire logic        [COORD_BITS-2:0]      h_a,
    input  wire logic        [COORD_BITS-2:0]      w_b,
    input  wire logic        [COORD_BITS-2:0]      h_b,
    output logic                                   ok
);
    import ortp_pkg::*;

    localparam int PW = 2 * SIN_W;           // sine product
    localparam int UW = PW;                  // magnitude of a sum of two products
    localparam int DW = COORD_BITS + 1 + SIN_W;
    localparam int MW = COORD_BITS - 1 + UW;
    localparam int RW = COORD_BITS + 33;

    logic signed [PW-1:0] ua1_reg, ua2_reg, va1_reg, va2_reg;
    logic signed [PW-1:0] ub1_reg, ub2_reg, vb1_reg, vb2_reg;
    logic signed [DW-1:0] pdx_reg, pdy_reg;

    logic        [UW-1:0] ua_reg, va_reg, ub_reg, vb_reg;
    logic        [DW-1:0] d_reg;

    logic        [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic        [RW-1:0] dsh_reg;
    logic                 ok_reg;

    logic signed [PW:0]   ua_s, va_s, ub_s, vb_s;
    logic signed [DW:0]   d_s;
    logic        [RW-1:0] r_sum;

    function automatic logic [UW-1:0] mag_u(input logic signed [PW:0] v);
        logic signed [PW:0] a;
        a = v[PW] ? -v : v;
        return a[UW-1:0];
    endfunction

    always_comb begin
        ua_s = (PW+1)'(ua1_reg) + (PW+1)'(ua2_reg);
        va_s = (PW+1)'(va2_reg) - (PW+1)'(va1_reg);
        ub_s = (PW+1)'(ub1_reg) + (PW+1)'(ub2_reg);
        vb_s = (PW+1)'(vb2_reg) - (PW+1)'(vb1_reg);
        d_s  = (DW+1)'(pdx_reg) + (DW+1)'(pdy_reg);
        r_sum = RW'(m1_reg) + RW'(m2_reg) + RW'(m3_reg) + RW'(m4_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.prod_en) begin
            ua1_reg <= cs_a * ax;
            ua2_reg <= sn_a * ay;
            va1_reg <= sn_a * ax;
            va2_reg <= cs_a * ay;
            ub1_reg <= cs_b * ax;
            ub2_reg <= sn_b * ay;
            vb1_reg <= sn_b * ax;
            vb2_reg <= cs_b * ay;
            pdx_reg <= DW'(dx) * DW'(ax);
            pdy_reg <= DW'(dy) * DW'(ay);
        end
        if (ctl.sum_en) begin
            ua_reg <= mag_u(ua_s);
            va_reg <= mag_u(va_s);
            ub_reg <= mag_u(ub_s);
            vb_reg <= mag_u(vb_s);
            d_reg  <= d_s[DW] ? DW'(-d_s) : DW'(d_s);
        end
        if (ctl.mul_en) begin
            m1_reg  <= MW'(w_a) * MW'(ua_reg);
            m2_reg  <= MW'(h_a) * MW'(va_reg);
            m3_reg  <= MW'(w_b) * MW'(ub_reg);
            m4_reg  <= MW'(h_b) * MW'(vb_reg);
            // centre distance is Q14; doubled and brought to the Q28 of the products, i.e. scaled by 2^15
            dsh_reg <= RW'(d_reg) << 15;
        end
        if (ctl.ok_en) begin
            ok_reg <= (dsh_reg <= r_sum);
        end
    end

    assign ok = ok_reg;

endmodule
`default_nettype wire
